>>> rtl/plo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plo_pkg: shared types and constants
// Widths, cell codes and fixed point constants for the pairwise log odds
// block. The front, queue and back ends and the channel interfaces use them.
// ----------------------------------------------------------------------------
package plo_pkg;

    // member vector and attribute select
    localparam int MEMBER_W   = 16;
    localparam int ATTRIBUTES = 16;
    localparam int ATTR_W     = $clog2(ATTRIBUTES);

    // contingency cells
    localparam int CELLS       = 4;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int CNT_W       = 17;
    localparam int MAX_MEMBERS = 65536;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef t_cnt [CELLS-1:0]   t_cells;
    typedef logic [CELL_W-1:0]  t_cell;

    // cell code = {first bit, second bit}
    localparam t_cell CELL_NEITHER     = 2'd0;
    localparam t_cell CELL_SECOND_ONLY = 2'd1;
    localparam t_cell CELL_FIRST_ONLY  = 2'd2;
    localparam t_cell CELL_BOTH        = 2'd3;

    localparam t_cnt CNT_MAX = CNT_W'(MAX_MEMBERS);

    // configuration registers
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = ATTR_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_ATTR  = 1'b0,
        REG_SECOND_ATTR = 1'b1
    } t_cfg_reg;

    localparam logic [ATTR_W-1:0] FIRST_ATTR_RST  = ATTR_W'(0);
    localparam logic [ATTR_W-1:0] SECOND_ATTR_RST = ATTR_W'(1);

    // log2 / ln datapath
    localparam int MUL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int EXP_W     = 5;            // top bit index of a count, 0..16
    localparam int LN_W      = 21;           // ln(count) in Q.16, below 2^20
    localparam int SUM_W     = 24;           // signed sum of four ln terms
    localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [SUM_W-1:0] LN_MILLI_Q16 = -24'sd452707;

    // log odds output, Q7.12
    localparam int LOG_W = 19;
    localparam logic signed [SUM_W-1:0] LOG_HI = SUM_W'((2 ** (LOG_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] LOG_LO = -LOG_HI - SUM_W'(1);

    // sigmoid datapath: x = 1000 * c fits 27 bits for MAX_MEMBERS = 65536
    localparam int X_W   = 27;
    localparam int PQ_W  = 2 * X_W;
    localparam int DEN_W = PQ_W + 1;
    localparam int QUO_W = 17;
    localparam int SIG_W = 16;
    localparam logic [9:0] SCALE_MILLI = 10'd1000;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int STEP_W = 5;

endpackage
`default_nettype wire

>>> rtl/plo_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plo_ifs: channel interfaces
// Valid/ready channels for member words, result words and register writes.
// ----------------------------------------------------------------------------
interface plo_member_if import plo_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MEMBER_W-1:0] member_bits;
    logic                final_member;

    modport source (output valid, output member_bits, output final_member, input ready);
    modport sink   (input valid, input member_bits, input final_member, output ready);
endinterface

interface plo_result_if import plo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SIG_W-1:0]        interaction;
    logic signed [LOG_W-1:0] log_odds;
    logic [CNT_W-1:0]        count_neither;
    logic [CNT_W-1:0]        count_second_only;
    logic [CNT_W-1:0]        count_first_only;
    logic [CNT_W-1:0]        count_both;

    modport source (output valid, output interaction, output log_odds,
                    output count_neither, output count_second_only,
                    output count_first_only, output count_both, input ready);
    modport sink   (input valid, input interaction, input log_odds,
                    input count_neither, input count_second_only,
                    input count_first_only, input count_both, output ready);
endinterface

interface plo_cfg_if import plo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/plo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plo_front: member intake and cell counting
// Picks the two configured bits of each member, bumps one of four saturating
// counters, and on the final member pushes the counts to the queue and clears.
// ----------------------------------------------------------------------------
module plo_front import plo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plo_member_if.sink i_member,
    plo_cfg_if.sink    i_cfg,
    input  logic      i_q_full,
    output logic      o_q_push,
    output t_cells    o_q_cells
);

    logic [ATTR_W-1:0] r_first_attr;
    logic [ATTR_W-1:0] r_second_attr;
    t_cells            r_cnt;
    t_cells            n_cnt;
    t_cells            inc_cnt;
    t_cell             pair_code;
    logic              accept;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_attr  <= FIRST_ATTR_RST;
            r_second_attr <= SECOND_ATTR_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.addr))
                REG_FIRST_ATTR:  r_first_attr  <= i_cfg.data;
                REG_SECOND_ATTR: r_second_attr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // intake: only a full queue holds off members
    assign i_member.ready = !i_q_full;
    assign accept         = i_member.valid && i_member.ready;

    assign pair_code = {i_member.member_bits[r_first_attr],
                        i_member.member_bits[r_second_attr]};

    // saturating increment, clear after the final member
    always_comb begin
        inc_cnt = r_cnt;
        if (accept && (r_cnt[pair_code] < CNT_MAX)) begin
            inc_cnt[pair_code] = r_cnt[pair_code] + t_cnt'(1);
        end
        n_cnt = (accept && i_member.final_member) ? '0 : inc_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_q_push  = accept && i_member.final_member;
    assign o_q_cells = inc_cnt;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_MAX) && (r_cnt[1] <= CNT_MAX) &&
        (r_cnt[2] <= CNT_MAX) && (r_cnt[3] <= CNT_MAX))
        else $error("cell counter above population bound");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_cnt == '0))
        else $error("counters not cleared after final member");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("push into full queue");

endmodule
`default_nettype wire

>>> rtl/plo_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plo_fifo: population queue
// Small register queue of finished count sets between front and back ends.
// ----------------------------------------------------------------------------
module plo_fifo import plo_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cells i_push_cells,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_cells o_cells
);

    t_cells                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W:0]   r_fill;

    assign o_full  = (r_fill == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cells = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cells;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + FIFO_PTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (FIFO_PTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (FIFO_PTR_W+1)'(1);
                default: ;
            endcase
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("queue fill level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || o_full) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

>>> rtl/plo_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plo_back: log odds and sigmoid engine
// Sequencer around one shared 32x32 multiplier. Per cell: normalize, sixteen
// squaring steps for log2 and scale by ln 2 (nonzero only), accumulate. Then
// scale counts by 1000, form both diagonal products, long-divide P/(P + Q).
// ----------------------------------------------------------------------------
module plo_back import plo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cells      i_q_cells,
    output logic        o_q_pop,
    plo_result_if.source o_result
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_NORM  = 10'b0000000010,
        S_SQ    = 10'b0000000100,
        S_LN    = 10'b0000001000,
        S_ACC   = 10'b0000010000,
        S_SCALE = 10'b0000100000,
        S_PROD  = 10'b0001000000,
        S_DSET  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_back_state;

    t_back_state             r_state;
    t_cells                  r_cells;
    t_cell                   r_k;
    logic [STEP_W-1:0]       r_step;
    logic [MUL_W-1:0]        r_m;
    logic [EXP_W-1:0]        r_exp;
    logic [FRAC_BITS-1:0]    r_frac;
    logic                    r_zero;
    logic [LN_W-1:0]         r_ln;
    logic signed [SUM_W-1:0] r_sum;
    logic [X_W-1:0]          r_x [CELLS];
    logic [PQ_W-1:0]         r_p;
    logic [PQ_W-1:0]         r_q;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_quo;

    logic                    r_out_valid;
    logic [SIG_W-1:0]        r_out_sig;
    logic signed [LOG_W-1:0] r_out_log;
    t_cells                  r_out_cells;

    t_cnt                    cur_c;
    logic [EXP_W-1:0]        lead;
    logic [MUL_W-1:0]        norm_m;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [2*MUL_W-1:0]      prod;
    logic [MUL_W:0]          sq;
    logic [2*MUL_W-1:0]      ln_rnd;
    logic signed [SUM_W-1:0] term;
    logic [DEN_W:0]          rem2;
    logic signed [SUM_W-1:0] sum_rnd;
    logic signed [SUM_W-1:0] sum_sh;
    logic signed [LOG_W-1:0] log_val;
    logic [QUO_W:0]          quo_rnd;
    logic [SIG_W-1:0]        sig_val;
    logic                    out_load;

    assign cur_c = r_cells[r_k];

    // top set bit and Q1.31 mantissa of the current count
    always_comb begin
        lead = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (cur_c[i]) lead = EXP_W'(i);
        end
        norm_m = MUL_W'(cur_c) << (EXP_W'(MUL_W - 1) - lead);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            S_LN: begin
                mul_a = MUL_W'({r_exp, r_frac});
                mul_b = LN2_Q32;
            end
            S_SCALE: begin
                mul_a = MUL_W'(cur_c);
                mul_b = MUL_W'(SCALE_MILLI);
            end
            S_PROD: begin
                mul_a = MUL_W'(r_step[0] ? r_x[CELL_SECOND_ONLY] : r_x[CELL_NEITHER]);
                mul_b = MUL_W'(r_step[0] ? r_x[CELL_FIRST_ONLY]  : r_x[CELL_BOTH]);
            end
            default: ;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign sq     = prod[2*MUL_W-1:MUL_W-1];
    assign ln_rnd = prod + (2*MUL_W)'(64'h8000_0000);

    // ln term: diagonal cells add, off-diagonal cells subtract
    assign term = r_zero ? LN_MILLI_Q16 : SUM_W'(r_ln);
    assign rem2 = {r_rem, 1'b0};

    // output shaping: round-half-up divide by 16, saturate to Q7.12
    always_comb begin
        sum_rnd = r_sum + SUM_W'(8);
        sum_sh  = sum_rnd >>> 4;
        if (sum_sh > LOG_HI) begin
            log_val = LOG_W'(LOG_HI);
        end else if (sum_sh < LOG_LO) begin
            log_val = LOG_W'(LOG_LO);
        end else begin
            log_val = LOG_W'(sum_sh);
        end
        quo_rnd = {1'b0, r_quo} + (QUO_W+1)'(1);
        sig_val = quo_rnd[QUO_W] ? '1 : quo_rnd[QUO_W-1:1];
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_NORM;
                        r_k     <= '0;
                    end
                end
                S_NORM: begin
                    r_step  <= '0;
                    r_state <= (cur_c == '0) ? S_ACC : S_SQ;
                end
                S_SQ: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(FRAC_BITS - 1)) r_state <= S_LN;
                end
                S_LN: r_state <= S_ACC;
                S_ACC: begin
                    r_k <= r_k + CELL_W'(1);
                    r_state <= (r_k == CELL_W'(CELLS - 1)) ? S_SCALE : S_NORM;
                end
                S_SCALE: begin
                    r_k    <= r_k + CELL_W'(1);
                    r_step <= '0;
                    if (r_k == CELL_W'(CELLS - 1)) r_state <= S_PROD;
                end
                S_PROD: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step[0]) r_state <= S_DSET;
                end
                S_DSET: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(QUO_W - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cells <= i_q_cells;
                r_sum   <= '0;
            end
            S_NORM: begin
                r_zero <= (cur_c == '0);
                r_exp  <= lead;
                r_m    <= norm_m;
                r_frac <= '0;
            end
            S_SQ: begin
                // square, renormalize, shift out one log2 fraction bit
                r_frac <= {r_frac[FRAC_BITS-2:0], sq[MUL_W]};
                r_m    <= sq[MUL_W] ? sq[MUL_W:1] : sq[MUL_W-1:0];
            end
            S_LN: r_ln <= ln_rnd[MUL_W+LN_W-1:MUL_W];
            S_ACC: begin
                if (r_k == CELL_NEITHER || r_k == CELL_BOTH) begin
                    r_sum <= r_sum + term;
                end else begin
                    r_sum <= r_sum - term;
                end
            end
            S_SCALE: r_x[r_k] <= (cur_c == '0) ? X_W'(1) : prod[X_W-1:0];
            S_PROD: begin
                if (r_step[0]) r_q <= prod[PQ_W-1:0];
                else           r_p <= prod[PQ_W-1:0];
            end
            S_DSET: begin
                r_den <= {1'b0, r_p} + {1'b0, r_q};
                r_rem <= {1'b0, r_p};
                r_quo <= '0;
            end
            S_DIV: begin
                // one restoring division step per cycle
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= DEN_W'(rem2 - {1'b0, r_den});
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2[DEN_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // result register, frees the engine while a word waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sig   <= sig_val;
            r_out_log   <= log_val;
            r_out_cells <= r_cells;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.interaction       = r_out_sig;
    assign o_result.log_odds          = r_out_log;
    assign o_result.count_neither     = r_out_cells[CELL_NEITHER];
    assign o_result.count_second_only = r_out_cells[CELL_SECOND_ONLY];
    assign o_result.count_first_only  = r_out_cells[CELL_FIRST_ONLY];
    assign o_result.count_both        = r_out_cells[CELL_BOTH];

    // checks
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out_sig)
            && $stable(r_out_log) && $stable(r_out_cells)))
        else $error("result word changed while waiting");

    a_cells_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_k == CELL_W'(CELLS - 1)) |=> (r_state == S_SCALE))
        else $error("log pass did not hand over to scaling");

endmodule
`default_nettype wire

>>> rtl/pairwise_log_odds_sigmoid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_log_odds_sigmoid: 2x2 contingency log odds ratio with sigmoid
// Counts member bit pairs into four cells and, per population, returns the
// log odds ratio (Q7.12), its logistic sigmoid (Q0.16) and the four counts.
//
//   channel    dir  word                                   accepted when
//   i_member   in   member_bits, final_member              valid & ready
//   o_result   out  interaction, log_odds, four counts     valid & ready
//   i_cfg      in   addr (0 first, 1 second attr), data    valid & ready
//
// Members are taken one per cycle; ready drops only while the population
// queue (4 entries) is full. The back end takes one population at a time:
// per nonzero cell it normalizes, squares for log2 on the shared
// multiplier, scales by ln 2 and accumulates (a zero cell skips to the
// accumulate), then scales, multiplies, sets up and divides. A result
// word waits in an output register; the engine only holds in its done
// state when the next word is finished before the waiting one leaves.
// Reset is synchronous: counters, queue and sequencer clear, attrs go 0/1.
// ----------------------------------------------------------------------------
module pairwise_log_odds_sigmoid import plo_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plo_member_if.sink   i_member,
    plo_result_if.source o_result,
    plo_cfg_if.sink      i_cfg
);

    logic   q_full;
    logic   q_push;
    t_cells q_push_cells;
    logic   q_pop;
    logic   q_valid;
    t_cells q_cells;

    // front end: intake and counting
    plo_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_member  (i_member),
        .i_cfg     (i_cfg),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_cells (q_push_cells)
    );

    // queue of finished populations
    plo_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_cells (q_push_cells),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_cells      (q_cells)
    );

    // back end: log odds and sigmoid
    plo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cells (q_cells),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire
